[design/assert_macros.svh]
// Shared assertion macros for the encoder RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[design/xibe_pkg.sv]
package xibe_pkg;

  // Request types.
  localparam logic [3:0] OP_MOV      = 4'd0;
  localparam logic [3:0] OP_ADD      = 4'd1;
  localparam logic [3:0] OP_SUB      = 4'd2;
  localparam logic [3:0] OP_MUL      = 4'd3;
  localparam logic [3:0] OP_LOAD     = 4'd4;
  localparam logic [3:0] OP_STORE    = 4'd5;
  localparam logic [3:0] OP_JMP      = 4'd6;
  localparam logic [3:0] OP_JCC      = 4'd7;
  localparam logic [3:0] OP_CALL     = 4'd8;
  localparam logic [3:0] OP_RET      = 4'd9;
  localparam logic [3:0] OP_OTHER    = 4'd10;
  localparam logic [3:0] OP_PROLOGUE = 4'd11;

  // Operand kinds.
  localparam logic [1:0] KIND_IMM  = 2'd0;
  localparam logic [1:0] KIND_REG  = 2'd1;
  localparam logic [1:0] KIND_SLOT = 2'd2;

  // Opcode and prefix bytes.
  localparam logic [7:0] BYTE_REX_W    = 8'h48;
  localparam logic [7:0] BYTE_MOV_IMM  = 8'hB8;
  localparam logic [7:0] BYTE_GRP1_IB  = 8'h83;
  localparam logic [7:0] BYTE_ESC      = 8'h0F;
  localparam logic [7:0] BYTE_IMUL     = 8'hAF;
  localparam logic [7:0] BYTE_MOV_LOAD = 8'h8B;
  localparam logic [7:0] BYTE_MOV_ST   = 8'h89;
  localparam logic [7:0] BYTE_ADD_RR   = 8'h01;
  localparam logic [7:0] BYTE_SUB_RR   = 8'h29;
  localparam logic [7:0] BYTE_JMP      = 8'hE9;
  localparam logic [7:0] BYTE_JNE      = 8'h85;
  localparam logic [7:0] BYTE_CALL     = 8'hE8;
  localparam logic [7:0] BYTE_LEAVE    = 8'hC9;
  localparam logic [7:0] BYTE_RET      = 8'hC3;
  localparam logic [7:0] BYTE_NOP      = 8'h90;
  localparam logic [7:0] BYTE_PUSH_RBP = 8'h55;
  localparam logic [7:0] BYTE_MODRM_BP = 8'hE5;

  localparam logic [1:0] MOD_DISP8  = 2'd1;
  localparam logic [1:0] MOD_DISP32 = 2'd2;
  localparam logic [1:0] MOD_REG    = 2'd3;
  localparam logic [2:0] RM_RBP     = 3'd5;
  localparam logic [2:0] EXT_ADD    = 3'd0;
  localparam logic [2:0] EXT_SUB    = 3'd5;
  localparam logic [2:0] REG_RAX    = 3'd0;

  localparam int unsigned MAX_BYTES = 7;

  typedef struct packed {
    logic [3:0]         req_type;
    logic [1:0]         operand_count;
    logic [1:0]         source_kind;
    logic [2:0]         dest_reg;
    logic [2:0]         src_reg;
    logic signed [31:0] immediate;
    logic [15:0]        slot_index;
  } req_t;

  typedef struct packed {
    logic [7:0]  code_byte;
    logic [31:0] byte_position;
    logic        reloc_start;
    logic        last;
  } rsp_t;

  // One encoded instruction as it travels from front to back.
  typedef struct packed {
    logic [2:0]                 len;
    logic [MAX_BYTES-1:0]       rel;
    logic [MAX_BYTES-1:0][7:0]  bytes;
  } enc_t;

  function automatic logic [7:0] modrm(logic [1:0] mode, logic [2:0] rg, logic [2:0] rmf);
    modrm = {mode, rg, rmf};
  endfunction

endpackage

[design/x86_instruction_byte_encoder_top.sv]
// Channel | Handshake             | Payload          | Moves
// req     | req_valid, req_ready  | xibe_pkg::req_t  | one instruction in
// rsp     | rsp_valid, rsp_ready  | xibe_pkg::rsp_t  | one code byte out
//
// Each instruction produces one to seven bytes, one byte per cycle from the
// back end's output register whenever rsp is not stalled.
// Requests that encode to nothing are dropped in the front stage and emit no byte.
// A QUEUE_DEPTH-entry queue (two by default) sits between encoder and byte sequencer.
// Synchronous reset clears the byte offset to zero and empties every stage.
// A stalled rsp holds its byte; requests are taken until queue and front stage fill.
module x86_instruction_byte_encoder_top #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  output logic            req_ready,
  input  xibe_pkg::req_t  req,
  output logic            rsp_valid,
  input  logic            rsp_ready,
  output xibe_pkg::rsp_t  rsp
);

  logic           f_valid;
  logic           f_ready;
  xibe_pkg::enc_t f_enc;
  logic           q_valid;
  logic           q_ready;
  xibe_pkg::enc_t q_enc;

  xibe_front u_front (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .enc_valid (f_valid),
    .enc_ready (f_ready),
    .enc       (f_enc)
  );

  xibe_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_data  (f_enc),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_data   (q_enc)
  );

  xibe_back u_back (
    .clk       (clk),
    .rst       (rst),
    .enc_valid (q_valid),
    .enc_ready (q_ready),
    .enc       (q_enc),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

endmodule

[design/xibe_front.sv]
`include "assert_macros.svh"

module xibe_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  output logic            req_ready,
  input  xibe_pkg::req_t  req,
  output logic            enc_valid,
  input  logic            enc_ready,
  output xibe_pkg::enc_t  enc
);

  xibe_pkg::enc_t enc_next;
  logic           stage_valid;
  logic [19:0]    slot_off;
  logic [31:0]    disp;
  logic           short_disp;
  logic           cnt_any;
  logic           cnt_two;
  logic [2:0]     slot_reg;

  assign cnt_any    = (req.operand_count != 2'd0);
  assign cnt_two    = req.operand_count[1];
  assign slot_off   = {(17'(req.slot_index) + 17'd1), 3'b000};
  assign disp       = 32'd0 - 32'(slot_off);
  assign short_disp = (slot_off <= 20'd127);
  assign slot_reg   = (req.req_type == xibe_pkg::OP_LOAD) ? req.dest_reg : req.src_reg;

  always_comb begin
    enc_next = '0;
    case (req.req_type)
      xibe_pkg::OP_MOV: begin
        if (cnt_any && req.source_kind == xibe_pkg::KIND_IMM) begin
          enc_next.bytes[0] = xibe_pkg::BYTE_MOV_IMM + {5'd0, req.dest_reg};
          enc_next.bytes[1] = req.immediate[7:0];
          enc_next.bytes[2] = req.immediate[15:8];
          enc_next.bytes[3] = req.immediate[23:16];
          enc_next.bytes[4] = req.immediate[31:24];
          enc_next.len      = 3'd5;
        end else if (cnt_any && req.source_kind == xibe_pkg::KIND_REG) begin
          enc_next.bytes[0] = xibe_pkg::BYTE_REX_W;
          enc_next.bytes[1] = xibe_pkg::BYTE_MOV_ST;
          enc_next.bytes[2] = xibe_pkg::modrm(xibe_pkg::MOD_REG, req.src_reg, req.dest_reg);
          enc_next.len      = 3'd3;
        end
      end
      xibe_pkg::OP_ADD, xibe_pkg::OP_SUB: begin
        if (cnt_two && req.source_kind == xibe_pkg::KIND_IMM) begin
          enc_next.bytes[0] = xibe_pkg::BYTE_GRP1_IB;
          enc_next.bytes[1] = xibe_pkg::modrm(xibe_pkg::MOD_REG,
              (req.req_type == xibe_pkg::OP_ADD) ? xibe_pkg::EXT_ADD : xibe_pkg::EXT_SUB,
              req.dest_reg);
          enc_next.bytes[2] = req.immediate[7:0];
          enc_next.len      = 3'd3;
        end else if (cnt_two && req.source_kind == xibe_pkg::KIND_REG) begin
          enc_next.bytes[0] = xibe_pkg::BYTE_REX_W;
          enc_next.bytes[1] = (req.req_type == xibe_pkg::OP_ADD) ?
                              xibe_pkg::BYTE_ADD_RR : xibe_pkg::BYTE_SUB_RR;
          enc_next.bytes[2] = xibe_pkg::modrm(xibe_pkg::MOD_REG, req.src_reg, req.dest_reg);
          enc_next.len      = 3'd3;
        end
      end
      xibe_pkg::OP_MUL: begin
        if (cnt_any) begin
          enc_next.bytes[0] = xibe_pkg::BYTE_REX_W;
          enc_next.bytes[1] = xibe_pkg::BYTE_ESC;
          enc_next.bytes[2] = xibe_pkg::BYTE_IMUL;
          enc_next.bytes[3] = xibe_pkg::modrm(xibe_pkg::MOD_REG, req.src_reg, xibe_pkg::REG_RAX);
          enc_next.len      = 3'd4;
        end
      end
      xibe_pkg::OP_LOAD, xibe_pkg::OP_STORE: begin
        // Load needs an operand, store two; both address [rbp - 8*(slot_index+1)].
        if (((req.req_type == xibe_pkg::OP_LOAD) ? cnt_any : cnt_two) &&
            req.source_kind == xibe_pkg::KIND_SLOT) begin
          enc_next.bytes[0] = xibe_pkg::BYTE_REX_W;
          enc_next.bytes[1] = (req.req_type == xibe_pkg::OP_LOAD) ?
                              xibe_pkg::BYTE_MOV_LOAD : xibe_pkg::BYTE_MOV_ST;
          if (short_disp) begin
            enc_next.bytes[2] = xibe_pkg::modrm(xibe_pkg::MOD_DISP8, slot_reg, xibe_pkg::RM_RBP);
            enc_next.bytes[3] = disp[7:0];
            enc_next.len      = 3'd4;
          end else begin
            enc_next.bytes[2] = xibe_pkg::modrm(xibe_pkg::MOD_DISP32, slot_reg, xibe_pkg::RM_RBP);
            enc_next.bytes[3] = disp[7:0];
            enc_next.bytes[4] = disp[15:8];
            enc_next.bytes[5] = disp[23:16];
            enc_next.bytes[6] = disp[31:24];
            enc_next.len      = 3'd7;
          end
        end
      end
      xibe_pkg::OP_JMP, xibe_pkg::OP_CALL: begin
        if (cnt_any) begin
          enc_next.bytes[0] = (req.req_type == xibe_pkg::OP_JMP) ?
                              xibe_pkg::BYTE_JMP : xibe_pkg::BYTE_CALL;
          enc_next.rel[1]   = 1'b1;
          enc_next.len      = 3'd5;
        end
      end
      xibe_pkg::OP_JCC: begin
        if (cnt_any) begin
          enc_next.bytes[0] = xibe_pkg::BYTE_ESC;
          enc_next.bytes[1] = xibe_pkg::BYTE_JNE;
          enc_next.rel[2]   = 1'b1;
          enc_next.len      = 3'd6;
        end
      end
      xibe_pkg::OP_RET: begin
        enc_next.bytes[0] = xibe_pkg::BYTE_LEAVE;
        enc_next.bytes[1] = xibe_pkg::BYTE_RET;
        enc_next.len      = 3'd2;
      end
      xibe_pkg::OP_PROLOGUE: begin
        enc_next.bytes[0] = xibe_pkg::BYTE_PUSH_RBP;
        enc_next.bytes[1] = xibe_pkg::BYTE_REX_W;
        enc_next.bytes[2] = xibe_pkg::BYTE_MOV_ST;
        enc_next.bytes[3] = xibe_pkg::BYTE_MODRM_BP;
        enc_next.len      = 3'd4;
      end
      default: begin
        enc_next.bytes[0] = xibe_pkg::BYTE_NOP;
        enc_next.len      = 3'd1;
      end
    endcase
  end

  assign req_ready = !stage_valid || enc_ready;
  assign enc_valid = stage_valid;

  // Requests that encode to nothing are dropped here and never reach the queue.
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (req_ready) begin
      stage_valid <= req_valid && (enc_next.len != 3'd0);
    end
  end

  always_ff @(posedge clk) begin
    if (req_ready && req_valid) begin
      enc <= enc_next;
    end
  end

  `ASSERT_ALWAYS(a_front_nonempty, clk, rst, !stage_valid || (enc.len != 3'd0), "empty encoding staged")

endmodule

[design/xibe_queue.sv]
`include "assert_macros.svh"

module xibe_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push_valid,
  output logic            push_ready,
  input  xibe_pkg::enc_t  push_data,
  output logic            pop_valid,
  input  logic            pop_ready,
  output xibe_pkg::enc_t  pop_data
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  xibe_pkg::enc_t     mem [DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;
  logic               push;
  logic               pop;

  assign push_ready = (count != CNT_W'(DEPTH));
  assign pop_valid  = (count != '0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_data   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  `ASSERT_ALWAYS(a_queue_bound, clk, rst, count <= CNT_W'(DEPTH), "queue count overflow")

endmodule

[design/xibe_back.sv]
`include "assert_macros.svh"

module xibe_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            enc_valid,
  output logic            enc_ready,
  input  xibe_pkg::enc_t  enc,
  output logic            rsp_valid,
  input  logic            rsp_ready,
  output xibe_pkg::rsp_t  rsp
);

  logic [2:0]  idx;
  logic [31:0] offset;
  logic        load;
  logic        at_last;

  assign load      = enc_valid && (!rsp_valid || rsp_ready);
  assign at_last   = (idx == enc.len - 3'd1);
  assign enc_ready = load && at_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      idx       <= '0;
      offset    <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (load) begin
        idx       <= at_last ? 3'd0 : idx + 3'd1;
        offset    <= offset + 32'd1;
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      rsp.code_byte     <= enc.bytes[idx];
      rsp.byte_position <= offset;
      rsp.reloc_start   <= enc.rel[idx];
      rsp.last          <= at_last;
    end
  end

  `ASSERT_ALWAYS(a_back_idx, clk, rst, !enc_valid || (idx < enc.len), "byte index past encoding")
  `ASSERT_NEXT(a_back_pos, clk, rst, load,
               rsp_valid && (rsp.byte_position + 32'd1 == offset), "byte position out of step")

endmodule

[verif/tb.sv]
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  // The package names three operand kinds; the fourth is "anything else".
  localparam logic [1:0] KIND_OTHER = 2'd3;
  // Highest request type code, which falls outside the defined operations.
  localparam logic [3:0] OP_UNDEF_TOP = 4'd15;
  localparam int unsigned MAX_REPORTS = 10;

  logic clk;
  logic rst;
  logic req_valid;
  logic req_ready;
  xibe_pkg::req_t req;
  logic rsp_valid;
  logic rsp_ready;
  xibe_pkg::rsp_t rsp;

  // Expected code bytes, oldest first, and the predicted text offset.
  xibe_pkg::rsp_t expected_bytes [$];
  logic [31:0]    text_offset;

  int unsigned error_count;
  int unsigned instrs_sent;
  int unsigned empty_instrs;
  int unsigned bytes_checked;
  int unsigned out_hold_cycles;
  bit          tx_gaps;
  bit          rx_stalls;

  x86_instruction_byte_encoder_top dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("Run timed out with %0d bytes still expected", expected_bytes.size());
    $display("DONE: errors detected");
    $finish;
  end

  // Mostly short gaps, now and then a long one.
  function automatic int unsigned pick_gap();
    if ($urandom_range(0, 9) == 0) begin
      return $urandom_range(10, 40);
    end
    return $urandom_range(1, 3);
  endfunction

  function automatic xibe_pkg::req_t instr(logic [3:0] op, logic [1:0] cnt, logic [1:0] kind,
                                           logic [2:0] dst, logic [2:0] src,
                                           logic [31:0] imm, logic [15:0] slot);
    xibe_pkg::req_t r;
    r.req_type      = op;
    r.operand_count = cnt;
    r.source_kind   = kind;
    r.dest_reg      = dst;
    r.src_reg       = src;
    r.immediate     = imm;
    r.slot_index    = slot;
    return r;
  endfunction

  // Works out the code bytes of one instruction and queues them with their offsets.
  function automatic void predict_bytes(xibe_pkg::req_t r);
    logic [7:0]     code [$];
    logic [31:0]    frame_off;
    logic [31:0]    disp;
    logic [2:0]     slot_reg;
    int             rel_at;
    xibe_pkg::rsp_t e;
    rel_at    = -1;
    frame_off = (32'(r.slot_index) + 32'd1) * 32'd8;
    disp      = 32'd0 - frame_off;
    slot_reg  = (r.req_type == xibe_pkg::OP_LOAD) ? r.dest_reg : r.src_reg;
    case (r.req_type)
      xibe_pkg::OP_MOV: begin
        if (r.operand_count != 2'd0 && r.source_kind == xibe_pkg::KIND_IMM) begin
          code = {code, xibe_pkg::BYTE_MOV_IMM + {5'd0, r.dest_reg}};
          code = {code, r.immediate[7:0]};
          code = {code, r.immediate[15:8]};
          code = {code, r.immediate[23:16]};
          code = {code, r.immediate[31:24]};
        end else if (r.operand_count != 2'd0 && r.source_kind == xibe_pkg::KIND_REG) begin
          code = {code, xibe_pkg::BYTE_REX_W};
          code = {code, xibe_pkg::BYTE_MOV_ST};
          code = {code, xibe_pkg::modrm(xibe_pkg::MOD_REG, r.src_reg, r.dest_reg)};
        end
      end
      xibe_pkg::OP_ADD, xibe_pkg::OP_SUB: begin
        if (r.operand_count >= 2'd2 && r.source_kind == xibe_pkg::KIND_IMM) begin
          code = {code, xibe_pkg::BYTE_GRP1_IB};
          code = {code, xibe_pkg::modrm(xibe_pkg::MOD_REG,
                  (r.req_type == xibe_pkg::OP_ADD) ? xibe_pkg::EXT_ADD : xibe_pkg::EXT_SUB,
                  r.dest_reg)};
          code = {code, r.immediate[7:0]};
        end else if (r.operand_count >= 2'd2 && r.source_kind == xibe_pkg::KIND_REG) begin
          code = {code, xibe_pkg::BYTE_REX_W};
          code = {code, (r.req_type == xibe_pkg::OP_ADD) ?
                        xibe_pkg::BYTE_ADD_RR : xibe_pkg::BYTE_SUB_RR};
          code = {code, xibe_pkg::modrm(xibe_pkg::MOD_REG, r.src_reg, r.dest_reg)};
        end
      end
      xibe_pkg::OP_MUL: begin
        if (r.operand_count != 2'd0) begin
          code = {code, xibe_pkg::BYTE_REX_W};
          code = {code, xibe_pkg::BYTE_ESC};
          code = {code, xibe_pkg::BYTE_IMUL};
          code = {code, xibe_pkg::modrm(xibe_pkg::MOD_REG, r.src_reg, xibe_pkg::REG_RAX)};
        end
      end
      xibe_pkg::OP_LOAD, xibe_pkg::OP_STORE: begin
        if (r.source_kind == xibe_pkg::KIND_SLOT &&
            ((r.req_type == xibe_pkg::OP_LOAD && r.operand_count != 2'd0) ||
             (r.req_type == xibe_pkg::OP_STORE && r.operand_count >= 2'd2))) begin
          code = {code, xibe_pkg::BYTE_REX_W};
          code = {code, (r.req_type == xibe_pkg::OP_LOAD) ?
                        xibe_pkg::BYTE_MOV_LOAD : xibe_pkg::BYTE_MOV_ST};
          // Frame offsets up to 127 fit a signed 8-bit displacement.
          if (frame_off <= 32'd127) begin
            code = {code, xibe_pkg::modrm(xibe_pkg::MOD_DISP8, slot_reg, xibe_pkg::RM_RBP)};
            code = {code, disp[7:0]};
          end else begin
            code = {code, xibe_pkg::modrm(xibe_pkg::MOD_DISP32, slot_reg, xibe_pkg::RM_RBP)};
            code = {code, disp[7:0]};
            code = {code, disp[15:8]};
            code = {code, disp[23:16]};
            code = {code, disp[31:24]};
          end
        end
      end
      xibe_pkg::OP_JMP, xibe_pkg::OP_JCC, xibe_pkg::OP_CALL: begin
        if (r.operand_count != 2'd0) begin
          if (r.req_type == xibe_pkg::OP_JCC) begin
            code = {code, xibe_pkg::BYTE_ESC};
            code = {code, xibe_pkg::BYTE_JNE};
          end else begin
            code = {code, (r.req_type == xibe_pkg::OP_JMP) ?
                          xibe_pkg::BYTE_JMP : xibe_pkg::BYTE_CALL};
          end
          rel_at = code.size();
          repeat (4) code = {code, 8'h00};
        end
      end
      xibe_pkg::OP_RET: begin
        code = {code, xibe_pkg::BYTE_LEAVE};
        code = {code, xibe_pkg::BYTE_RET};
      end
      xibe_pkg::OP_PROLOGUE: begin
        code = {code, xibe_pkg::BYTE_PUSH_RBP};
        code = {code, xibe_pkg::BYTE_REX_W};
        code = {code, xibe_pkg::BYTE_MOV_ST};
        code = {code, xibe_pkg::BYTE_MODRM_BP};
      end
      default: begin
        code = {code, xibe_pkg::BYTE_NOP};
      end
    endcase
    if (code.size() == 0) begin
      empty_instrs++;
    end
    for (int k = 0; k < code.size(); k++) begin
      e.code_byte     = code[k];
      e.byte_position = text_offset;
      e.reloc_start   = (k == rel_at);
      e.last          = (k == code.size() - 1);
      expected_bytes  = {expected_bytes, e};
      text_offset     = text_offset + 32'd1;
    end
  endfunction

  // Mostly well-formed instructions with random content, the rest random noise.
  function automatic xibe_pkg::req_t random_instr();
    xibe_pkg::req_t r;
    if ($urandom_range(0, 9) == 0) begin
      r.req_type = 4'($urandom_range(int'(xibe_pkg::OP_PROLOGUE) + 1, int'(OP_UNDEF_TOP)));
    end else begin
      r.req_type = 4'($urandom_range(0, int'(xibe_pkg::OP_PROLOGUE)));
    end
    r.operand_count = 2'($urandom);
    r.source_kind   = 2'($urandom);
    r.dest_reg      = 3'($urandom);
    r.src_reg       = 3'($urandom);
    r.immediate     = $urandom;
    if ($urandom_range(0, 3) == 0) begin
      r.slot_index = 16'($urandom);
    end else begin
      r.slot_index = 16'($urandom_range(0, 20));
    end
    if ($urandom_range(0, 9) < 8) begin
      r.operand_count = $urandom_range(0, 1) ? 2'd2 : 2'd3;
      case (r.req_type)
        xibe_pkg::OP_MOV, xibe_pkg::OP_ADD, xibe_pkg::OP_SUB:
          r.source_kind = $urandom_range(0, 1) ? xibe_pkg::KIND_REG : xibe_pkg::KIND_IMM;
        xibe_pkg::OP_LOAD, xibe_pkg::OP_STORE:
          r.source_kind = xibe_pkg::KIND_SLOT;
        default: ;
      endcase
    end
    return r;
  endfunction

  // Offers one request and returns at the edge where it is taken; valid stays high.
  task automatic send_instr(xibe_pkg::req_t r);
    if (tx_gaps && $urandom_range(0, 3) == 0) begin
      req_valid <= 1'b0;
      repeat (pick_gap()) @(posedge clk);
    end
    req       <= r;
    req_valid <= 1'b1;
    do @(posedge clk); while (!req_ready);
    predict_bytes(r);
    instrs_sent++;
  endtask

  task automatic drain_requests();
    req_valid <= 1'b0;
    while (expected_bytes.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic send_random(int unsigned count);
    repeat (count) send_instr(random_instr());
  endtask

  task automatic test_directed();
    tx_gaps   = 1'b0;
    rx_stalls = 1'b0;
    send_instr(instr(xibe_pkg::OP_PROLOGUE, 2'd0, KIND_OTHER, 3'd0, 3'd0, 32'h0, 16'd0));
    send_instr(instr(xibe_pkg::OP_MOV, 2'd2, xibe_pkg::KIND_IMM, 3'd0, 3'd7,
                     32'h8000_0000, 16'd0));
    send_instr(instr(xibe_pkg::OP_MOV, 2'd1, xibe_pkg::KIND_IMM, 3'd7, 3'd0,
                     32'h7FFF_FFFF, 16'd0));
    send_instr(instr(xibe_pkg::OP_MOV, 2'd2, xibe_pkg::KIND_REG, 3'd7, 3'd7,
                     32'hFFFF_FFFF, 16'hFFFF));
    send_instr(instr(xibe_pkg::OP_ADD, 2'd2, xibe_pkg::KIND_IMM, 3'd3, 3'd5,
                     32'h0000_00FF, 16'd0));
    send_instr(instr(xibe_pkg::OP_SUB, 2'd3, xibe_pkg::KIND_IMM, 3'd6, 3'd1,
                     32'hFFFF_FF80, 16'd0));
    send_instr(instr(xibe_pkg::OP_ADD, 2'd2, xibe_pkg::KIND_REG, 3'd0, 3'd7, 32'h0, 16'd0));
    send_instr(instr(xibe_pkg::OP_SUB, 2'd2, xibe_pkg::KIND_REG, 3'd7, 3'd0, 32'h0, 16'd0));
    // Multiply never looks at the operand kind.
    send_instr(instr(xibe_pkg::OP_MUL, 2'd1, KIND_OTHER, 3'd2, 3'd7, 32'h0, 16'd0));
    // Slot 14 is the last one with an 8-bit displacement, slot 15 the first without.
    send_instr(instr(xibe_pkg::OP_LOAD, 2'd1, xibe_pkg::KIND_SLOT, 3'd7, 3'd0, 32'h0, 16'd0));
    send_instr(instr(xibe_pkg::OP_LOAD, 2'd2, xibe_pkg::KIND_SLOT, 3'd1, 3'd0, 32'h0, 16'd14));
    send_instr(instr(xibe_pkg::OP_LOAD, 2'd2, xibe_pkg::KIND_SLOT, 3'd4, 3'd0, 32'h0, 16'd15));
    send_instr(instr(xibe_pkg::OP_STORE, 2'd2, xibe_pkg::KIND_SLOT, 3'd0, 3'd7,
                     32'h0, 16'hFFFF));
    send_instr(instr(xibe_pkg::OP_STORE, 2'd3, xibe_pkg::KIND_SLOT, 3'd0, 3'd2,
                     32'h0, 16'd1));
    send_instr(instr(xibe_pkg::OP_JMP, 2'd1, xibe_pkg::KIND_IMM, 3'd0, 3'd0, 32'h0, 16'd0));
    send_instr(instr(xibe_pkg::OP_JCC, 2'd1, xibe_pkg::KIND_SLOT, 3'd0, 3'd0, 32'h0, 16'd0));
    send_instr(instr(xibe_pkg::OP_CALL, 2'd2, xibe_pkg::KIND_REG, 3'd0, 3'd0, 32'h0, 16'd0));
    send_instr(instr(xibe_pkg::OP_RET, 2'd0, KIND_OTHER, 3'd0, 3'd0, 32'h0, 16'd0));
    send_instr(instr(xibe_pkg::OP_OTHER, 2'd0, xibe_pkg::KIND_IMM, 3'd0, 3'd0, 32'h0, 16'd0));
    send_instr(instr(OP_UNDEF_TOP, 2'd3, KIND_OTHER, 3'd7, 3'd7, 32'hFFFF_FFFF, 16'hFFFF));
    // Missing operands and unsupported operand kinds produce no bytes.
    send_instr(instr(xibe_pkg::OP_MOV, 2'd0, xibe_pkg::KIND_IMM, 3'd1, 3'd1,
                     32'h1234_5678, 16'd0));
    send_instr(instr(xibe_pkg::OP_ADD, 2'd1, xibe_pkg::KIND_REG, 3'd1, 3'd1, 32'h0, 16'd0));
    send_instr(instr(xibe_pkg::OP_STORE, 2'd1, xibe_pkg::KIND_SLOT, 3'd1, 3'd1, 32'h0, 16'd3));
    send_instr(instr(xibe_pkg::OP_MOV, 2'd2, xibe_pkg::KIND_SLOT, 3'd1, 3'd1, 32'h0, 16'd0));
    send_instr(instr(xibe_pkg::OP_SUB, 2'd2, KIND_OTHER, 3'd1, 3'd1, 32'h0, 16'd0));
    send_instr(instr(xibe_pkg::OP_LOAD, 2'd2, xibe_pkg::KIND_REG, 3'd1, 3'd1, 32'h0, 16'd0));
    send_instr(instr(xibe_pkg::OP_STORE, 2'd2, xibe_pkg::KIND_IMM, 3'd1, 3'd1, 32'h0, 16'd0));
    drain_requests();
  endtask

  task automatic test_random_traffic();
    tx_gaps   = 1'b1;
    rx_stalls = 1'b1;
    send_random(70);
  endtask

  task automatic test_full_rate();
    tx_gaps   = 1'b0;
    rx_stalls = 1'b0;
    send_random(20);
  endtask

  // The receiver stops for a long stretch while requests keep coming.
  task automatic test_output_stall();
    tx_gaps         = 1'b0;
    rx_stalls       = 1'b0;
    out_hold_cycles <= 150;
    send_random(20);
  endtask

  task automatic test_drain_pause();
    tx_gaps   = 1'b1;
    rx_stalls = 1'b1;
    send_random(8);
    drain_requests();
    send_random(8);
  endtask

  // Receiver side: random stalls, plus one long hold when a test asks for it.
  initial begin : receiver
    int unsigned n;
    rsp_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (out_hold_cycles != 0) begin
        n = out_hold_cycles;
        out_hold_cycles = 0;
        rsp_ready <= 1'b0;
        repeat (n) @(posedge clk);
        rsp_ready <= 1'b1;
      end else if (rx_stalls && $urandom_range(0, 4) == 0) begin
        rsp_ready <= 1'b0;
        repeat (pick_gap()) @(posedge clk);
        rsp_ready <= 1'b1;
      end else begin
        rsp_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : byte_checker
    xibe_pkg::rsp_t e;
    if (!rst && rsp_valid && rsp_ready) begin
      if (expected_bytes.size() == 0) begin
        error_count++;
        if (error_count <= MAX_REPORTS) begin
          $display("Unexpected byte %02h at position %08h", rsp.code_byte, rsp.byte_position);
        end
      end else begin
        e = expected_bytes.pop_front();
        bytes_checked++;
        if (rsp.code_byte !== e.code_byte || rsp.byte_position !== e.byte_position ||
            rsp.reloc_start !== e.reloc_start || rsp.last !== e.last) begin
          error_count++;
          if (error_count <= MAX_REPORTS) begin
            $display("Byte mismatch: expected %02h pos %08h reloc %b last %b,",
                     e.code_byte, e.byte_position, e.reloc_start, e.last,
                     " got %02h pos %08h reloc %b last %b",
                     rsp.code_byte, rsp.byte_position, rsp.reloc_start, rsp.last);
          end
        end
      end
    end
  end

  initial begin
    rst             <= 1'b1;
    req_valid       <= 1'b0;
    req             <= '0;
    text_offset     = 32'd0;
    error_count     = 0;
    instrs_sent     = 0;
    empty_instrs    = 0;
    bytes_checked   = 0;
    out_hold_cycles = 0;
    tx_gaps         = 1'b0;
    rx_stalls       = 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_random_traffic();
    test_full_rate();
    test_output_stall();
    test_drain_pause();

    drain_requests();
    repeat (20) @(posedge clk);
    if (expected_bytes.size() != 0) begin
      $display("%0d expected bytes never arrived", expected_bytes.size());
      error_count += expected_bytes.size();
    end
    $display("Encoded %0d instructions (%0d with no code) into %0d checked bytes,",
             instrs_sent, empty_instrs, bytes_checked);
    $display("under random gaps, full-rate bursts, a long output stall and a full drain.");
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

[x86_instruction_byte_encoder_top.f]
+incdir+design
design/xibe_pkg.sv
design/xibe_front.sv
design/xibe_queue.sv
design/xibe_back.sv
design/x86_instruction_byte_encoder_top.sv
verif/tb.sv
